FILE: src/gcp_pkg.sv
// gcp_pkg: shared types and widths for the greedy clique partition block
// holds the input and output beat structs and the command codes
// no dependencies
package gcp_pkg;

    localparam int ROW_W   = 32;
    localparam int NODE_W  = 5;
    localparam int LABEL_W = 6;
    localparam int CNT_W   = 6;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_START = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd               command;
        logic [NODE_W-1:0]  row_index;
        logic [ROW_W-1:0]   row_bits;
    } t_in_beat;

    typedef struct packed {
        logic [NODE_W-1:0]  node_index;
        logic [LABEL_W-1:0] group_label;
        logic [CNT_W-1:0]   group_count;
        logic               last;
    } t_out_beat;

endpackage

FILE: src/greedy_clique_partition.sv
// greedy_clique_partition: top level, greedy clique cover over a conflict matrix
// depends on gcp_pkg; conflict rows and group labels live in memories with registered reads
// a load beat writes one row; a start beat walks each target k: read row k, wait, scan k..n-1,
// with a join step per node that joins, then emits n beats of read, load, emit (held on stall)
// one input beat at a time (input stalls unless idle); the scan loop and the row-memory port set the time
// reset (synchronous, active low) clears the assigned flags, sets node_count to 32; rows stay undefined
module greedy_clique_partition #(
    parameter int MAX_NODES = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [gcp_pkg::CNT_W-1:0] i_cfg_wr_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  gcp_pkg::t_in_beat         i_in_beat,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output gcp_pkg::t_out_beat        o_out_beat
);
    import gcp_pkg::*;

    localparam int DEPTH = (MAX_NODES < ROW_W) ? MAX_NODES : ROW_W;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_K_RD,
        ST_K_WAIT,
        ST_SCAN,
        ST_JOIN,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_node_count;
    logic [CNT_W-1:0]   r_n;
    logic [CNT_W-1:0]   r_k;
    logic [CNT_W-1:0]   r_i;
    logic [CNT_W-1:0]   r_j;
    logic [LABEL_W-1:0] r_next_label;
    logic [ROW_W-1:0]   r_row_k;
    logic [ROW_W-1:0]   r_forbid;
    logic [DEPTH-1:0]   r_assigned;
    logic               r_nonempty;
    logic               r_out_valid;
    t_out_beat          r_out_beat;

    logic [ROW_W-1:0]   mtx_mem [DEPTH];
    logic [ROW_W-1:0]   r_mtx_rd;
    logic [LABEL_W-1:0] lbl_mem [DEPTH];
    logic [LABEL_W-1:0] r_lbl_rd;

    logic               in_accept;
    logic               mtx_we;
    logic [AW-1:0]      mtx_rd_addr;
    logic               lbl_we;
    logic [CNT_W-1:0]   n_limit;
    logic               scan_end;
    logic               cand;
    logic [CNT_W-1:0]   k_inc;
    logic [CNT_W-1:0]   j_inc;

    assign in_accept = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall = (r_state != ST_IDLE);
    assign mtx_we = in_accept && (i_in_beat.command == CMD_LOAD)
                    && (ROW_W'(i_in_beat.row_index) < ROW_W'(DEPTH));
    assign n_limit = (r_node_count > DEPTH_CNT) ? DEPTH_CNT : r_node_count;
    assign scan_end = (r_i >= r_n);
    assign cand = !r_row_k[r_i[NODE_W-1:0]] && !r_assigned[r_i[AW-1:0]]
                  && !r_forbid[r_i[NODE_W-1:0]];
    assign mtx_rd_addr = (r_state == ST_K_RD) ? r_k[AW-1:0] : r_i[AW-1:0];
    assign lbl_we = (r_state == ST_SCAN) && !scan_end && cand;
    assign k_inc = r_k + 1'b1;
    assign j_inc = r_j + 1'b1;

    // conflict row memory
    always_ff @(posedge i_clk) begin
        if (mtx_we) begin
            mtx_mem[i_in_beat.row_index[AW-1:0]] <= i_in_beat.row_bits;
        end
        r_mtx_rd <= mtx_mem[mtx_rd_addr];
    end

    // group label memory, valid through r_assigned
    always_ff @(posedge i_clk) begin
        if (lbl_we) begin
            lbl_mem[r_i[AW-1:0]] <= r_next_label;
        end
        r_lbl_rd <= lbl_mem[r_j[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_node_count <= CNT_W'(32);
            r_n          <= '0;
            r_k          <= '0;
            r_i          <= '0;
            r_j          <= '0;
            r_next_label <= LABEL_W'(1);
            r_assigned   <= '0;
            r_nonempty   <= 1'b0;
            r_forbid     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_node_count <= i_cfg_wr_data;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_accept && (i_in_beat.command == CMD_START)) begin
                        r_assigned   <= '0;
                        r_next_label <= LABEL_W'(1);
                        r_k          <= '0;
                        r_n          <= n_limit;
                        r_state      <= (n_limit == '0) ? ST_IDLE : ST_K_RD;
                    end
                end
                ST_K_RD: begin
                    r_state <= ST_K_WAIT;
                end
                ST_K_WAIT: begin
                    r_row_k    <= r_mtx_rd;
                    r_forbid   <= '0;
                    r_nonempty <= 1'b0;
                    r_i        <= r_k;
                    r_state    <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (scan_end) begin
                        if (r_nonempty) begin
                            r_next_label <= r_next_label + 1'b1;
                        end
                        r_k <= k_inc;
                        if (k_inc >= r_n) begin
                            r_j     <= '0;
                            r_state <= ST_EMIT_RD;
                        end else begin
                            r_state <= ST_K_RD;
                        end
                    end else begin
                        r_i <= r_i + 1'b1;
                        if (cand) begin
                            r_assigned[r_i[AW-1:0]] <= 1'b1;
                            r_nonempty              <= 1'b1;
                            r_state                 <= ST_JOIN;
                        end
                    end
                end
                ST_JOIN: begin
                    // fold the new member's row into the forbidden columns
                    r_forbid <= r_forbid | r_mtx_rd;
                    r_state  <= ST_SCAN;
                end
                ST_EMIT_RD: begin
                    r_state <= ST_EMIT_LD;
                end
                ST_EMIT_LD: begin
                    r_out_valid            <= 1'b1;
                    r_out_beat.node_index  <= r_j[NODE_W-1:0];
                    r_out_beat.group_label <= r_assigned[r_j[AW-1:0]] ? r_lbl_rd : '0;
                    r_out_beat.group_count <= r_next_label - 1'b1;
                    r_out_beat.last        <= (j_inc == r_n);
                    r_state                <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                        r_j         <= j_inc;
                        r_state     <= (j_inc >= r_n) ? ST_IDLE : ST_EMIT_RD;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule

FILE: test/tb_greedy_clique_partition.sv
// tb_greedy_clique_partition: self-checking bench for the greedy clique partition block
// runs directed rows and then random matrices, predicts every label beat and compares it
// depends on gcp_pkg and greedy_clique_partition
module tb_greedy_clique_partition;
    import gcp_pkg::*;

    localparam int NODES     = 32;
    localparam int SETTLE    = 200;
    localparam int LONG_HOLD = 3000;
    localparam int LIMIT     = 3000000;
    localparam int PHASES    = 8;

    typedef struct packed {
        t_cmd              cmd;
        logic [NODE_W-1:0] row;
        logic [ROW_W-1:0]  bits;
        logic              typed;
        logic [LABEL_W-1:0] lbl;
        logic [CNT_W-1:0]  cnt;
    } t_step;

    logic             i_clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_en = 1'b0;
    logic [CNT_W-1:0] cfg_data = '0;
    logic             in_valid = 1'b0;
    t_in_beat         in_beat = '0;
    logic             out_stall = 1'b0;
    logic             in_stall;
    logic             out_valid;
    t_out_beat        out_beat;

    logic [ROW_W-1:0]   conflict_rows [NODES];
    logic [LABEL_W-1:0] group_of [NODES];
    logic [CNT_W-1:0]   groups_formed;
    int                 node_cnt_reg = 32;
    t_out_beat          pending_labels [$];
    t_step              steps [19];

    int  errors = 0;
    int  beats_sent = 0;
    int  cycles = 0;
    bit  send_idle = 1'b1;
    bit  recv_idle = 1'b1;
    bit  hold_req = 1'b0;

    greedy_clique_partition #(
        .MAX_NODES(NODES)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_en),
        .i_cfg_wr_data(cfg_data),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_in_beat    (in_beat),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_out_beat   (out_beat)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb_greedy_clique_partition NOT OK");
            $finish;
        end
    end

    function automatic void partition_nodes(input int n);
        logic [ROW_W-1:0]   members;
        logic [LABEL_W-1:0] nxt;
        bit                 fits;
        for (int i = 0; i < NODES; i++) group_of[i] = '0;
        nxt = LABEL_W'(1);
        for (int k = 0; k < n; k++) begin
            members = '0;
            for (int i = k; i < n; i++) begin
                if (!conflict_rows[k][i] && group_of[i] == 0) begin
                    fits = 1'b1;
                    for (int m = 0; m < n; m++) begin
                        if (members[m] && conflict_rows[m][i]) fits = 1'b0;
                    end
                    if (fits) begin
                        members[i] = 1'b1;
                        group_of[i] = nxt;
                    end
                end
            end
            if (members != 0) nxt = nxt + 1'b1;
        end
        groups_formed = nxt - 1'b1;
    endfunction

    function automatic void absorb_beat(input t_in_beat b, input logic typed,
                                        input logic [LABEL_W-1:0] lbl,
                                        input logic [CNT_W-1:0] cnt);
        t_out_beat o;
        int        n;
        if (b.command == CMD_LOAD) begin
            conflict_rows[b.row_index] = b.row_bits;
        end else begin
            n = (node_cnt_reg > NODES) ? NODES : node_cnt_reg;
            partition_nodes(n);
            for (int i = 0; i < n; i++) begin
                o.node_index  = i[NODE_W-1:0];
                o.group_label = typed ? lbl : group_of[i];
                o.group_count = typed ? cnt : groups_formed;
                o.last        = (i == n - 1);
                pending_labels = {pending_labels, o};
            end
        end
    endfunction

    function automatic logic [ROW_W-1:0] make_row(input int r, input int style);
        logic [ROW_W-1:0] v;
        case (style)
            0: v = $urandom;
            1: v = $urandom & $urandom & $urandom;
            2: v = $urandom | $urandom;
            3: v = ~(32'h1 << r);
            4: v = '0;
            default: v = '1;
        endcase
        if (style < 3 && $urandom_range(0, 3) != 0) v[r] = 1'b0;
        return v;
    endfunction

    task automatic flag_mismatch(input string what, input int exp_v, input int act_v);
        errors++;
        $display("%0t: %s mismatch expected %0d actual %0d", $time, what, exp_v, act_v);
    endtask

    task automatic send_beat(input t_in_beat b, input logic typed,
                             input logic [LABEL_W-1:0] lbl, input logic [CNT_W-1:0] cnt);
        int gap;
        gap = send_idle ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        do @(posedge i_clk); while (in_stall);
        absorb_beat(b, typed, lbl, cnt);
        beats_sent++;
    endtask

    task automatic send_load(input int r, input logic [ROW_W-1:0] bits);
        t_in_beat b;
        b.command   = CMD_LOAD;
        b.row_index = r[NODE_W-1:0];
        b.row_bits  = bits;
        send_beat(b, 1'b0, '0, '0);
    endtask

    task automatic send_start();
        t_in_beat b;
        b.command   = CMD_START;
        b.row_index = NODE_W'($urandom);
        b.row_bits  = $urandom;
        send_beat(b, 1'b0, '0, '0);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_labels.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input int v);
        cfg_en   <= 1'b1;
        cfg_data <= v[CNT_W-1:0];
        @(posedge i_clk);
        cfg_en   <= 1'b0;
        node_cnt_reg = v;
    endtask

    // receiver: check each beat, then stall at random while recv_idle is set
    initial begin
        t_out_beat exp_b;
        int        hold;
        int        long_cnt;
        hold = 0;
        long_cnt = 0;
        forever begin
            @(posedge i_clk);
            if (out_valid && !out_stall && rst_n) begin
                if (pending_labels.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected beat expected none actual %h",
                             $time, out_beat);
                end else begin
                    exp_b = pending_labels.pop_front();
                    if (out_beat.node_index != exp_b.node_index)
                        flag_mismatch("node_index", int'(exp_b.node_index),
                                      int'(out_beat.node_index));
                    if (out_beat.group_label != exp_b.group_label)
                        flag_mismatch("group_label", int'(exp_b.group_label),
                                      int'(out_beat.group_label));
                    if (out_beat.group_count != exp_b.group_count)
                        flag_mismatch("group_count", int'(exp_b.group_count),
                                      int'(out_beat.group_count));
                    if (out_beat.last != exp_b.last)
                        flag_mismatch("last", int'(exp_b.last), int'(out_beat.last));
                end
                hold = recv_idle ? $urandom_range(0, 8) : 0;
            end
            if (hold_req) begin
                hold_req = 1'b0;
                long_cnt = LONG_HOLD;
            end
            if (long_cnt > 0) begin
                long_cnt--;
                out_stall <= 1'b1;
            end else if (hold > 0) begin
                hold--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    initial begin
        int       phase_nc [PHASES];
        int       budget;
        int       base;
        int       eff_n;
        int       loads;
        int       style;
        t_in_beat b;

        phase_nc = '{32, 1, 63, 0, 7, 32, 2, 0};
        phase_nc[7] = $urandom_range(8, 62);

        steps[0]  = '{CMD_START, 5'd0,  32'h0000_0000, 1'b1, 6'd1, 6'd1};
        steps[1]  = '{CMD_LOAD,  5'd0,  32'hFFFF_FFFF, 1'b0, 6'd0, 6'd0};
        steps[2]  = '{CMD_START, 5'd0,  32'h0000_0000, 1'b0, 6'd0, 6'd0};
        steps[3]  = '{CMD_LOAD,  5'd0,  32'h0000_0000, 1'b0, 6'd0, 6'd0};
        steps[4]  = '{CMD_LOAD,  5'd31, 32'h8000_0000, 1'b0, 6'd0, 6'd0};
        steps[5]  = '{CMD_START, 5'd31, 32'hFFFF_FFFF, 1'b0, 6'd0, 6'd0};
        steps[6]  = '{CMD_LOAD,  5'd31, 32'h0000_0000, 1'b0, 6'd0, 6'd0};
        steps[7]  = '{CMD_LOAD,  5'd1,  32'h0000_0004, 1'b0, 6'd0, 6'd0};
        steps[8]  = '{CMD_LOAD,  5'd2,  32'h0000_0002, 1'b0, 6'd0, 6'd0};
        steps[9]  = '{CMD_START, 5'd0,  32'h0000_0000, 1'b0, 6'd0, 6'd0};
        steps[10] = '{CMD_LOAD,  5'd3,  32'hAAAA_AAAA, 1'b0, 6'd0, 6'd0};
        steps[11] = '{CMD_LOAD,  5'd4,  32'h5555_5555, 1'b0, 6'd0, 6'd0};
        steps[12] = '{CMD_START, 5'd0,  32'h0000_0000, 1'b0, 6'd0, 6'd0};
        steps[13] = '{CMD_START, 5'd0,  32'h0000_0000, 1'b0, 6'd0, 6'd0};
        steps[14] = '{CMD_LOAD,  5'd1,  32'h0000_0000, 1'b0, 6'd0, 6'd0};
        steps[15] = '{CMD_LOAD,  5'd2,  32'h0000_0000, 1'b0, 6'd0, 6'd0};
        steps[16] = '{CMD_LOAD,  5'd3,  32'h0000_0000, 1'b0, 6'd0, 6'd0};
        steps[17] = '{CMD_LOAD,  5'd4,  32'h0000_0000, 1'b0, 6'd0, 6'd0};
        steps[18] = '{CMD_START, 5'd0,  32'h0000_0000, 1'b1, 6'd1, 6'd1};

        repeat (9) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // every row gets written before the first start reads it
        for (int r = 0; r < NODES; r++) send_load(r, '0);

        foreach (steps[s]) begin
            b.command   = steps[s].cmd;
            b.row_index = steps[s].row;
            b.row_bits  = steps[s].bits;
            send_beat(b, steps[s].typed, steps[s].lbl, steps[s].cnt);
        end

        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                wait_drained();
                repeat (SETTLE) @(posedge i_clk);
                cfg_write(phase_nc[p]);
            end
            eff_n = (phase_nc[p] > NODES) ? NODES : ((phase_nc[p] < 1) ? 1 : phase_nc[p]);
            budget = 40;
            base = beats_sent;
            if (p == 5) begin
                hold_req = 1'b1;
                send_idle = 1'b0;
            end
            while (beats_sent - base < budget) begin
                if ($urandom_range(0, 9) < 7) begin
                    style = $urandom_range(0, 5);
                    if ($urandom_range(0, 4) == 0) begin
                        for (int r = 0; r < eff_n; r++) send_load(r, make_row(r, style));
                    end else begin
                        loads = $urandom_range(1, (eff_n < 8) ? eff_n : 8);
                        repeat (loads) begin
                            int r;
                            r = $urandom_range(0, eff_n - 1);
                            send_load(r, make_row(r, style));
                        end
                    end
                    send_start();
                end else if ($urandom_range(0, 1) == 0) begin
                    send_load($urandom_range(0, NODES - 1), $urandom);
                end else begin
                    send_start();
                end
                if (p == 2 && beats_sent - base >= budget / 2 && beats_sent - base < budget / 2 + 3)
                    wait_drained();
                if ($urandom_range(0, 39) == 0) send_idle = ~send_idle;
                if ($urandom_range(0, 39) == 0) recv_idle = ~recv_idle;
            end
        end

        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb_greedy_clique_partition OK");
        end else begin
            $display("tb_greedy_clique_partition NOT OK");
        end
        $finish;
    end

endmodule
